/* rtl/lub_pkg.sv */
// ----------------------------------------------------------------------------
// lub_pkg
// Shared types and constants for the unaligned byte blit frame store.
// ----------------------------------------------------------------------------
package lub_pkg;

  localparam int DEF_PANEL_COLUMNS = 128;
  localparam int DEF_PANEL_ROWS    = 64;
  localparam int DEF_HALF_WIDTH    = 64;

  localparam int COORD_W    = 8;   // x and y position width
  localparam int PAGE_W     = 5;   // y / 8 of an 8-bit row
  localparam int BYTE_W     = 8;
  localparam int MODE_W     = 2;
  localparam int QUEUE_DEPTH = 2;

  localparam logic [MODE_W-1:0] MODE_OR      = 2'd0;
  localparam logic [MODE_W-1:0] MODE_XOR     = 2'd1;
  localparam logic [MODE_W-1:0] MODE_OR_INV  = 2'd2;
  localparam logic [MODE_W-1:0] MODE_XOR_INV = 2'd3;

  // One classified blit: low byte goes to page, high byte spills to page + 1.
  typedef struct packed {
    logic [COORD_W-1:0] col;
    logic [PAGE_W-1:0]  page;
    logic [BYTE_W-1:0]  lo_bits;
    logic [BYTE_W-1:0]  hi_bits;
    logic               spill;
  } lub_op_t;

endpackage

/* rtl/lub_front.sv */
// ----------------------------------------------------------------------------
// lub_front
// Accepts positions, drops those off the panel, applies pattern inversion and
// splits the shifted pattern into the page byte and the spill byte.
// ----------------------------------------------------------------------------
module lub_front import lub_pkg::*; #(
  parameter int PANEL_COLUMNS = DEF_PANEL_COLUMNS,
  parameter int PANEL_ROWS    = DEF_PANEL_ROWS
) (
  input  logic               in_valid,
  output logic               in_stall,
  input  logic [COORD_W-1:0] x_position,
  input  logic [COORD_W-1:0] y_position,
  input  logic [BYTE_W-1:0]  pattern,
  input  logic [MODE_W-1:0]  mode,
  input  logic               hold,
  input  logic               q_full,
  output logic               push,
  output lub_op_t            push_op
);

  localparam int PAGE_COUNT = (PANEL_ROWS + 7) / 8;

  logic              in_range;
  logic [BYTE_W-1:0] pat_eff;
  logic [2:0]        shift;
  logic [PAGE_W-1:0] page;
  logic [2*BYTE_W-1:0] wide;

  always_comb begin
    in_range = ({1'b0, x_position} < 9'(PANEL_COLUMNS)) &&
               ({1'b0, y_position} < 9'(PANEL_ROWS));
    pat_eff  = (mode == MODE_OR_INV || mode == MODE_XOR_INV) ? ~pattern : pattern;
    shift    = y_position[2:0];
    page     = y_position[COORD_W-1:3];
    wide     = {{BYTE_W{1'b0}}, pat_eff} << shift;

    push_op.col     = x_position;
    push_op.page    = page;
    push_op.lo_bits = wide[BYTE_W-1:0];
    push_op.hi_bits = wide[2*BYTE_W-1:BYTE_W];
    // no spill when aligned, or when the next page is past the panel
    push_op.spill   = (shift != 3'd0) &&
                      (({1'b0, page} + 6'd1) < 6'(PAGE_COUNT));

    in_stall = hold || q_full;
    push     = in_valid && !in_stall && in_range;
  end

endmodule

/* rtl/lub_queue.sv */
// ----------------------------------------------------------------------------
// lub_queue
// Short FIFO of classified blits between the front and the memory engine.
// ----------------------------------------------------------------------------
module lub_queue import lub_pkg::*; (
  input  logic    clk,
  input  logic    rst,
  input  logic    push,
  input  lub_op_t push_op,
  output logic    full,
  input  logic    pop,
  output logic    head_valid,
  output lub_op_t head_op
);

  localparam int PTR_W = $clog2(QUEUE_DEPTH);

  lub_op_t            entries [QUEUE_DEPTH];
  logic [PTR_W-1:0]   wr_ptr;
  logic [PTR_W-1:0]   rd_ptr;
  logic [PTR_W:0]     count;

  assign full       = (count == (PTR_W+1)'(QUEUE_DEPTH));
  assign head_valid = (count != '0);
  assign head_op    = entries[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr] <= push_op;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == PTR_W'(QUEUE_DEPTH-1)) ? '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == PTR_W'(QUEUE_DEPTH-1)) ? '0 : rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule

/* rtl/lub_back.sv */
// ----------------------------------------------------------------------------
// lub_back
// Read-modify-write engine on the frame memory: issues one byte read per
// cycle while the output is not stalled, merges and writes back from the
// write stage, and holds the output register. Also runs the clearing sweep
// after reset.
module lub_back import lub_pkg::*; #(
  parameter int PANEL_COLUMNS = DEF_PANEL_COLUMNS,
  parameter int PANEL_ROWS    = DEF_PANEL_ROWS,
  parameter int HALF_WIDTH    = DEF_HALF_WIDTH
) (
  input  logic              clk,
  input  logic              rst,
  input  logic [MODE_W-1:0] mode,
  input  logic              head_valid,
  input  lub_op_t           head_op,
  output logic              pop,
  output logic              clearing,
  output logic              out_valid,
  input  logic              out_stall,
  output logic              chip_select,
  output logic [2:0]        page_index,
  output logic [5:0]        column_index,
  output logic [BYTE_W-1:0] written_value,
  output logic              last
);

  localparam int PAGE_COUNT = (PANEL_ROWS + 7) / 8;
  localparam int STORE_SIZE = PAGE_COUNT * PANEL_COLUMNS;
  localparam int ADDR_W     = $clog2(STORE_SIZE);

  logic [BYTE_W-1:0] mem [STORE_SIZE];

  // clearing sweep
  logic [ADDR_W-1:0] clr_addr;

  // issue side
  logic              sub;          // 0: page byte, 1: spill byte
  logic              issue;
  logic              issue_last;
  logic [PAGE_W-1:0] sel_page;
  logic [ADDR_W-1:0] rd_addr;
  logic [BYTE_W-1:0] rd_data;

  // write stage
  logic              wr_valid;
  logic [ADDR_W-1:0] wr_addr;
  logic [BYTE_W-1:0] wr_bits;
  logic [COORD_W-1:0] wr_col;
  logic [PAGE_W-1:0] wr_page;
  logic              wr_last;
  logic              fwd;
  logic [BYTE_W-1:0] fwd_data;
  logic              wr_go;
  logic [BYTE_W-1:0] old_byte;
  logic [BYTE_W-1:0] merged;
  logic              chip;
  logic [COORD_W-1:0] local_col;

  always_comb begin
    wr_go      = wr_valid && (!out_valid || !out_stall);
    issue      = head_valid && !clearing && (!wr_valid || wr_go);
    issue_last = sub || !head_op.spill;
    pop        = issue && issue_last;
    sel_page   = sub ? head_op.page + 1'b1 : head_op.page;
    rd_addr    = ADDR_W'(sel_page) * ADDR_W'(PANEL_COLUMNS) + ADDR_W'(head_op.col);

    // bypass when the byte just written is the one read back
    old_byte   = fwd ? fwd_data : rd_data;
    merged     = (mode == MODE_XOR || mode == MODE_XOR_INV) ? (old_byte ^ wr_bits)
                                                            : (old_byte | wr_bits);
    chip       = ({1'b0, wr_col} >= 9'(HALF_WIDTH));
    local_col  = chip ? wr_col - COORD_W'(HALF_WIDTH) : wr_col;
  end

  always_ff @(posedge clk) begin
    if (clearing) begin
      mem[clr_addr] <= '0;
    end else if (wr_go) begin
      mem[wr_addr] <= merged;
    end
    if (issue) begin
      rd_data <= mem[rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (issue) begin
      wr_addr  <= rd_addr;
      wr_bits  <= sub ? head_op.hi_bits : head_op.lo_bits;
      wr_col   <= head_op.col;
      wr_page  <= sel_page;
      wr_last  <= issue_last;
      fwd_data <= merged;
    end
    if (wr_go) begin
      chip_select   <= chip;
      page_index    <= wr_page[2:0];
      column_index  <= local_col[5:0];
      written_value <= merged;
      last          <= wr_last;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      clearing  <= 1'b1;
      clr_addr  <= '0;
      sub       <= 1'b0;
      wr_valid  <= 1'b0;
      fwd       <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (clearing) begin
        clr_addr <= clr_addr + 1'b1;
        if (clr_addr == ADDR_W'(STORE_SIZE - 1)) begin
          clearing <= 1'b0;
        end
      end
      if (issue) begin
        sub      <= !issue_last;
        wr_valid <= 1'b1;
        fwd      <= wr_go && (wr_addr == rd_addr);
      end else if (wr_go) begin
        wr_valid <= 1'b0;
      end
      if (wr_go) begin
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

endmodule

/* rtl/lcd_unaligned_byte_blit.sv */
// ----------------------------------------------------------------------------
// lcd_unaligned_byte_blit
// Frame store for a two-controller monochrome panel with unaligned byte
// writes.
//
// Input channel (in_valid/in_stall) carries x_position, y_position, pattern.
// Each item on the panel causes one or two read-modify-write transfers on
// the output channel (out_valid/out_stall), one per page byte touched, with
// last set on the final one. Items off the panel are taken and dropped.
// cfg_we/cfg_wdata set the combine mode; write it only while idle.
// An input item is held in the queue, then in the read data and write stage
// registers, then in the output register whose out_valid offers the transfer.
// Throughput: one byte per cycle while the output is not stalled; an aligned
// or bottom-page item needs one byte transfer and a spilling one needs two.
// Reset: the memory is swept to zero, one byte per cycle, across all
// PAGE_COUNT * PANEL_COLUMNS bytes (1024 at default size); in_stall is held
// high meanwhile. A stalled output holds its result, the engine stops, and
// the two-entry queue then backs up into in_stall.
// ----------------------------------------------------------------------------
module lcd_unaligned_byte_blit import lub_pkg::*; #(
  parameter int PANEL_COLUMNS = DEF_PANEL_COLUMNS,
  parameter int PANEL_ROWS    = DEF_PANEL_ROWS,
  parameter int HALF_WIDTH    = DEF_HALF_WIDTH
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               cfg_we,
  input  logic [MODE_W-1:0]  cfg_wdata,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic [COORD_W-1:0] x_position,
  input  logic [COORD_W-1:0] y_position,
  input  logic [BYTE_W-1:0]  pattern,
  output logic               out_valid,
  input  logic               out_stall,
  output logic               chip_select,
  output logic [2:0]         page_index,
  output logic [5:0]         column_index,
  output logic [BYTE_W-1:0]  written_value,
  output logic               last
);

  logic [MODE_W-1:0] combine_mode;
  logic              clearing;
  logic              q_full;
  logic              push;
  lub_op_t           push_op;
  logic              pop;
  logic              head_valid;
  lub_op_t           head_op;

  always_ff @(posedge clk) begin
    if (rst) begin
      combine_mode <= MODE_OR;
    end else if (cfg_we) begin
      combine_mode <= cfg_wdata;
    end
  end

  lub_front #(
    .PANEL_COLUMNS (PANEL_COLUMNS),
    .PANEL_ROWS    (PANEL_ROWS)
  ) u_front (
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .x_position (x_position),
    .y_position (y_position),
    .pattern    (pattern),
    .mode       (combine_mode),
    .hold       (clearing),
    .q_full     (q_full),
    .push       (push),
    .push_op    (push_op)
  );

  lub_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .push       (push),
    .push_op    (push_op),
    .full       (q_full),
    .pop        (pop),
    .head_valid (head_valid),
    .head_op    (head_op)
  );

  lub_back #(
    .PANEL_COLUMNS (PANEL_COLUMNS),
    .PANEL_ROWS    (PANEL_ROWS),
    .HALF_WIDTH    (HALF_WIDTH)
  ) u_back (
    .clk           (clk),
    .rst           (rst),
    .mode          (combine_mode),
    .head_valid    (head_valid),
    .head_op       (head_op),
    .pop           (pop),
    .clearing      (clearing),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .chip_select   (chip_select),
    .page_index    (page_index),
    .column_index  (column_index),
    .written_value (written_value),
    .last          (last)
  );

endmodule

/* tb/sv/lcd_unaligned_byte_blit_test.sv */
// ----------------------------------------------------------------------------
// lcd_unaligned_byte_blit_test
// Self-checking bench for the unaligned byte blit frame store. A shadow frame
// buffer and combine mode predict each page write. Directed items hit the
// panel edges, chip boundary and page spills, then random traffic runs
// under every combine mode with varied sender and receiver idling.
// ----------------------------------------------------------------------------
module lcd_unaligned_byte_blit_test
  import lub_pkg::*;
();

  timeunit 1ns;
  timeprecision 1ps;

  localparam int PAGES = (DEF_PANEL_ROWS + 7) / 8;

  typedef struct packed {
    logic       chip;
    logic [2:0] page;
    logic [5:0] col;
    logic [7:0] value;
    logic       last;
  } lcd_write_t;

  logic               clk;
  logic               rst           = 1'b1;
  logic               cfg_we        = 1'b0;
  logic [MODE_W-1:0]  cfg_wdata     = MODE_OR;
  logic               in_valid      = 1'b0;
  logic               in_stall;
  logic [COORD_W-1:0] x_position    = '0;
  logic [COORD_W-1:0] y_position    = '0;
  logic [BYTE_W-1:0]  pattern       = '0;
  logic               out_valid;
  logic               out_stall     = 1'b0;
  logic               chip_select;
  logic [2:0]         page_index;
  logic [5:0]         column_index;
  logic [BYTE_W-1:0]  written_value;
  logic               last;

  logic [7:0]        frame_shadow [PAGES*DEF_PANEL_COLUMNS];
  logic [MODE_W-1:0] mode_shadow;
  lcd_write_t        blit_expect_q[$];
  int                err_count;
  int                snd_idle_pct;
  int                rcv_stall_pct;

  lcd_unaligned_byte_blit u_top (
    .clk           (clk),
    .rst           (rst),
    .cfg_we        (cfg_we),
    .cfg_wdata     (cfg_wdata),
    .in_valid      (in_valid),
    .in_stall      (in_stall),
    .x_position    (x_position),
    .y_position    (y_position),
    .pattern       (pattern),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .chip_select   (chip_select),
    .page_index    (page_index),
    .column_index  (column_index),
    .written_value (written_value),
    .last          (last)
  );

  always begin
    clk = 1'b0;
    #1;
    clk = 1'b1;
    #1;
  end

  // Read-modify-write of one shadow byte; queues the write it causes.
  function automatic void merge_into(int col, int pg, logic [7:0] bits, logic fin);
    int         addr;
    lcd_write_t w;
    addr = pg * DEF_PANEL_COLUMNS + col;
    frame_shadow[addr] = mode_shadow[0] ? (frame_shadow[addr] ^ bits)
                                        : (frame_shadow[addr] | bits);
    w.chip  = (col >= DEF_HALF_WIDTH);
    w.page  = pg[2:0];
    w.col   = w.chip ? 6'(col - DEF_HALF_WIDTH) : 6'(col);
    w.value = frame_shadow[addr];
    w.last  = fin;
    blit_expect_q.push_back(w);
  endfunction

  function automatic void predict_blit(logic [7:0] x, logic [7:0] y, logic [7:0] pat);
    logic [15:0] shifted;
    int          pg;
    logic        spill;
    if (x >= DEF_PANEL_COLUMNS || y >= DEF_PANEL_ROWS) return;
    // inversion happens before the shift, so vacated bits stay zero
    shifted = {8'h00, (mode_shadow[1] ? ~pat : pat)} << y[2:0];
    pg = int'(y[7:3]);
    spill = (y[2:0] != 3'd0) && (pg + 1 < PAGES);
    merge_into(int'(x), pg, shifted[7:0], !spill);
    if (spill) merge_into(int'(x), pg + 1, shifted[15:8], 1'b1);
  endfunction

  task automatic send_blit(input logic [7:0] x, input logic [7:0] y, input logic [7:0] pat);
    if ($urandom_range(99) < snd_idle_pct) begin
      in_valid <= 1'b0;
      do @(posedge clk); while ($urandom_range(99) < snd_idle_pct);
    end
    in_valid   <= 1'b1;
    x_position <= x;
    y_position <= y;
    pattern    <= pat;
    do @(posedge clk); while (in_stall);
    predict_blit(x, y, pat);
  endtask

  // Off-panel items leave no trace in the expected-write queue, so drain also idles after it empties.
  task automatic drain;
    in_valid <= 1'b0;
    while (blit_expect_q.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  task automatic set_mode(input logic [MODE_W-1:0] m);
    drain();
    cfg_we    <= 1'b1;
    cfg_wdata <= m;
    @(posedge clk);
    cfg_we      <= 1'b0;
    mode_shadow = m;
  endtask

  // Reset mode is OR; covers panel edges, chip boundary and spills.
  task automatic test_edges_after_reset;
    send_blit(8'd0,   8'd0,   8'hFF);
    send_blit(8'd127, 8'd63,  8'hFF);
    send_blit(8'd64,  8'd0,   8'h01);
    send_blit(8'd63,  8'd8,   8'h80);
    send_blit(8'd10,  8'd5,   8'hFF);
    send_blit(8'd10,  8'd5,   8'h00);
    send_blit(8'd128, 8'd0,   8'hFF);
    send_blit(8'd255, 8'd255, 8'hFF);
    send_blit(8'd0,   8'd64,  8'hFF);
    send_blit(8'd5,   8'd57,  8'hA5);
    send_blit(8'd5,   8'd55,  8'h5A);
  endtask

  task automatic test_combine_modes;
    logic [MODE_W-1:0] order [4];
    order = '{MODE_XOR, MODE_OR_INV, MODE_XOR_INV, MODE_OR};
    foreach (order[i]) begin
      set_mode(order[i]);
      send_blit(8'd20,  8'd3,  8'hC3);
      send_blit(8'd20,  8'd3,  8'hC3);
      send_blit(8'd127, 8'd62, 8'h00);
    end
  endtask

  task automatic run_random_phase(input int n_on_panel);
    int         sent;
    int         kind;
    int         hot_col;
    logic [7:0] x;
    logic [7:0] y;
    logic [7:0] p;
    sent = 0;
    hot_col = $urandom_range(DEF_PANEL_COLUMNS - 4);
    while (sent < n_on_panel) begin
      kind = $urandom_range(99);
      if (kind < 12) begin
        x = 8'($urandom);
        y = 8'($urandom);
      end else if (kind < 55) begin
        // narrow column window so bytes get rewritten often
        x = 8'(hot_col) + 8'($urandom_range(3));
        y = 8'($urandom_range(DEF_PANEL_ROWS - 1));
      end else begin
        x = 8'($urandom_range(DEF_PANEL_COLUMNS - 1));
        y = 8'($urandom_range(DEF_PANEL_ROWS - 1));
      end
      p = 8'($urandom);
      send_blit(x, y, p);
      if (x < DEF_PANEL_COLUMNS && y < DEF_PANEL_ROWS) sent++;
    end
  endtask

  task automatic test_random_traffic;
    logic [MODE_W-1:0] modes [4];
    modes = '{MODE_OR, MODE_XOR, MODE_OR_INV, MODE_XOR_INV};
    for (int prof = 0; prof < 3; prof++) begin
      case (prof)
        0: begin snd_idle_pct = 36; rcv_stall_pct = 50; end
        1: begin snd_idle_pct = 50; rcv_stall_pct = 36; end
        default: begin snd_idle_pct = 0; rcv_stall_pct = 0; end
      endcase
      for (int ph = 0; ph < 4; ph++) begin
        set_mode(modes[(ph + prof) % 4]);
        run_random_phase(61);
      end
    end
  endtask

  always @(posedge clk) begin : write_check
    lcd_write_t want;
    if (!rst && out_valid && !out_stall) begin
      if (blit_expect_q.size() == 0) begin
        $error("unexpected write transfer: page %0d col %0d value %02h",
               page_index, column_index, written_value);
        err_count++;
      end else begin
        want = blit_expect_q.pop_front();
        if (chip_select !== want.chip) begin
          $error("chip_select: expected %0d, got %0d", want.chip, chip_select);
          err_count++;
        end
        if (page_index !== want.page) begin
          $error("page_index: expected %0d, got %0d", want.page, page_index);
          err_count++;
        end
        if (column_index !== want.col) begin
          $error("column_index: expected %0d, got %0d", want.col, column_index);
          err_count++;
        end
        if (written_value !== want.value) begin
          $error("written_value: expected %02h, got %02h", want.value, written_value);
          err_count++;
        end
        if (last !== want.last) begin
          $error("last: expected %0d, got %0d", want.last, last);
          err_count++;
        end
      end
    end
    out_stall <= ($urandom_range(99) < rcv_stall_pct);
  end

  initial begin
    err_count = 0;
    mode_shadow = MODE_OR;
    snd_idle_pct = 36;
    rcv_stall_pct = 50;
    foreach (frame_shadow[i]) frame_shadow[i] = 8'h00;
    repeat (3) @(posedge clk);
    rst <= 1'b0;
    test_edges_after_reset();
    test_combine_modes();
    test_random_traffic();
    drain();
    if (err_count == 0) begin
      $display("lcd_unaligned_byte_blit_test: done, clean");
    end else begin
      $display("lcd_unaligned_byte_blit_test: done, errors");
    end
    $finish;
  end

  // clear sweep plus ~850 items at worst-case idling fits well inside this
  initial begin
    #400_000;
    $display("lcd_unaligned_byte_blit_test: done, errors");
    $finish;
  end

endmodule
